### src/tbc_pkg.sv
`default_nettype none

package tbc_pkg;

    localparam int PIX_W    = 8;
    localparam int THR_W    = 8;
    localparam int SIZE_W   = 12;
    localparam int COORD_W  = 11;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int TDATA_W  = 24;

    localparam logic [1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [THR_W-1:0]  THRESHOLD_RST    = 8'd0;
    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    typedef struct packed {
        logic [THR_W-1:0]  threshold;
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
    } tbc_cfg_t;

    typedef struct packed {
        logic               frame_end;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
    } tbc_result_t;

endpackage

`default_nettype wire

### src/tbc_apb.sv
`default_nettype none

module tbc_apb (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [tbc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [tbc_pkg::DATA_W-1:0] pwdata,
    output logic      [tbc_pkg::DATA_W-1:0] prdata,
    output logic                           pready,
    output tbc_pkg::tbc_cfg_t              cfg
);
    import tbc_pkg::*;

    tbc_cfg_t   cfg_reg;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold    <= THRESHOLD_RST;
            cfg_reg.frame_width  <= FRAME_WIDTH_RST;
            cfg_reg.frame_height <= FRAME_HEIGHT_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_THRESHOLD:    cfg_reg.threshold    <= pwdata[THR_W-1:0];
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= pwdata[SIZE_W-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_THRESHOLD:    prdata = DATA_W'(cfg_reg.threshold);
            REG_FRAME_WIDTH:  prdata = DATA_W'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = DATA_W'(cfg_reg.frame_height);
            default:          prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### src/tbc_track.sv
`default_nettype none

module tbc_track #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      advance,
    input  wire logic [tbc_pkg::PIX_W-1:0] pixel,
    input  tbc_pkg::tbc_cfg_t              cfg,
    output tbc_pkg::tbc_result_t           res
);
    import tbc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
    localparam int HW = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

    logic [CW-1:0] col_reg, lc_reg, gc_reg, lc_next, gc_next, cx_diff, cx;
    logic [RW-1:0] row_reg, lr_reg, gr_reg, lr_next, gr_next, cy_diff, cy;
    logic          found_reg, found_next, pass;
    logic [WW-1:0] fw_ext, w_eff;
    logic [HW-1:0] fh_ext, h_eff;
    logic          last_col, last_row, frame_end;

    assign fw_ext = WW'(cfg.frame_width);
    assign fh_ext = HW'(cfg.frame_height);

    always_comb begin
        priority if (fw_ext == '0)              w_eff = WW'(1);
        else if (fw_ext > WW'(MAX_WIDTH))       w_eff = WW'(MAX_WIDTH);
        else                                    w_eff = fw_ext;
        priority if (fh_ext == '0)              h_eff = HW'(1);
        else if (fh_ext > HW'(MAX_HEIGHT))      h_eff = HW'(MAX_HEIGHT);
        else                                    h_eff = fh_ext;
    end

    assign last_col  = (WW'(col_reg) + WW'(1)) >= w_eff;
    assign last_row  = (HW'(row_reg) + HW'(1)) >= h_eff;
    assign frame_end = last_col && last_row;
    assign pass      = pixel > cfg.threshold;

    always_comb begin
        lc_next    = lc_reg;
        gc_next    = gc_reg;
        lr_next    = lr_reg;
        gr_next    = gr_reg;
        found_next = found_reg;
        if (pass) begin
            found_next = 1'b1;
            if (!found_reg) begin
                lc_next = col_reg;
                gc_next = col_reg;
                lr_next = row_reg;
                gr_next = row_reg;
            end else begin
                if (col_reg < lc_reg) lc_next = col_reg;
                if (col_reg > gc_reg) gc_next = col_reg;
                if (row_reg < lr_reg) lr_next = row_reg;
                if (row_reg > gr_reg) gr_next = row_reg;
            end
        end
    end

    assign cx_diff = gc_next - lc_next;
    assign cy_diff = gr_next - lr_next;
    assign cx      = found_next ? lc_next + (cx_diff >> 1) : '0;
    assign cy      = found_next ? lr_next + (cy_diff >> 1) : '0;

    assign res.frame_end = frame_end;
    assign res.center_x  = COORD_W'(cx);
    assign res.center_y  = COORD_W'(cy);

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && frame_end)) begin
            col_reg   <= '0;
            row_reg   <= '0;
            lc_reg    <= '0;
            gc_reg    <= '0;
            lr_reg    <= '0;
            gr_reg    <= '0;
            found_reg <= 1'b0;
        end else if (advance) begin
            lc_reg    <= lc_next;
            gc_reg    <= gc_next;
            lr_reg    <= lr_next;
            gr_reg    <= gr_next;
            found_reg <= found_next;
            if (last_col) begin
                col_reg <= '0;
                row_reg <= row_reg + RW'(1);
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### src/threshold_blob_center.sv
// A pixel that ends a frame is registered in pix_reg; once the result stage is free, cx_reg/cy_reg drive m_tdata.
// Throughput: one pixel per cycle while m_tready holds high; a stalled result
// holds only the last pixel of a frame, the others keep flowing.
// Reset: synchronous active-low aresetn clears the pipeline, counters and
// bounding box, and loads threshold 0, width 640, height 480.
`default_nettype none

module threshold_blob_center #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // pixel[7:0]
    input  wire logic [tbc_pkg::PIX_W-1:0]   s_tdata,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // center_x[10:0], center_y[21:11], zero[23:22]
    output logic      [tbc_pkg::TDATA_W-1:0] m_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tbc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [tbc_pkg::DATA_W-1:0]  pwdata,
    output logic      [tbc_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);
    import tbc_pkg::*;

    tbc_cfg_t           cfg;
    tbc_result_t        res;
    logic               in_valid_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic               out_valid_reg;
    logic [COORD_W-1:0] cx_reg, cy_reg;
    logic               out_free, advance;

    tbc_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbc_track #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .pixel   (pix_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (out_free || !res.frame_end);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            pix_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && res.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.frame_end) begin
            cx_reg <= res.center_x;
            cy_reg <= res.center_y;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W - 2 * COORD_W)'(0), cy_reg, cx_reg};

endmodule

`default_nettype wire

### src/tbc_checker.sv
`default_nettype none

module tbc_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result stage");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:22] == 2'b00)
        else $error("nonzero pad bits in result");

endmodule

bind threshold_blob_center tbc_checker u_tbc_checker (.*);

`default_nettype wire

### tb/tb_threshold_blob_center.sv
`default_nettype none

module tb_threshold_blob_center;
    timeunit 1ns;
    timeprecision 1ps;

    import tbc_pkg::*;

    localparam int MAX_W          = 2048;
    localparam int MAX_H          = 2048;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_PIXELS   = 220;
    localparam int MAX_REPORTS    = 10;

    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic [PIX_W-1:0]     s_tdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    threshold_blob_center #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } center_t;

    typedef enum logic [1:0] {OP_READ, OP_WRITE, OP_PIXEL} dir_op_e;

    typedef struct packed {
        dir_op_e            op;
        logic [1:0]         idx;
        logic [31:0]        value;
        logic               typed;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
    } dir_row_t;

    dir_row_t dir_tab [45] = '{
        '{OP_READ,  REG_THRESHOLD,    32'd0,         1'b0, 11'd0, 11'd0},
        '{OP_READ,  REG_FRAME_WIDTH,  32'd640,       1'b0, 11'd0, 11'd0},
        '{OP_READ,  REG_FRAME_HEIGHT, 32'd480,       1'b0, 11'd0, 11'd0},
        '{OP_WRITE, REG_FRAME_WIDTH,  32'd1,         1'b0, 11'd0, 11'd0},
        '{OP_WRITE, REG_FRAME_HEIGHT, 32'd1,         1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h00,        1'b1, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'hFF,        1'b1, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h01,        1'b1, 11'd0, 11'd0},
        '{OP_WRITE, REG_THRESHOLD,    32'hFF,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'hFF,        1'b1, 11'd0, 11'd0},
        '{OP_WRITE, REG_THRESHOLD,    32'h80,        1'b0, 11'd0, 11'd0},
        '{OP_WRITE, REG_FRAME_WIDTH,  32'hFFFF_F003, 1'b0, 11'd0, 11'd0},
        '{OP_WRITE, REG_FRAME_HEIGHT, 32'd2,         1'b0, 11'd0, 11'd0},
        '{OP_READ,  REG_FRAME_WIDTH,  32'd3,         1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h80,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h00,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h81,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h7F,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'hFF,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h00,        1'b1, 11'd1, 11'd0},
        '{OP_WRITE, REG_UNUSED,       32'hFF,        1'b0, 11'd0, 11'd0},
        '{OP_WRITE, REG_FRAME_WIDTH,  32'd2,         1'b0, 11'd0, 11'd0},
        '{OP_WRITE, REG_FRAME_HEIGHT, 32'd1,         1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h00,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h90,        1'b1, 11'd1, 11'd0},
        '{OP_READ,  REG_THRESHOLD,    32'h80,        1'b0, 11'd0, 11'd0},
        '{OP_WRITE, REG_FRAME_WIDTH,  32'd0,         1'b0, 11'd0, 11'd0},
        '{OP_WRITE, REG_FRAME_HEIGHT, 32'd0,         1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h81,        1'b1, 11'd0, 11'd0},
        '{OP_WRITE, REG_FRAME_WIDTH,  32'd3,         1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h00,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h00,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'hFF,        1'b1, 11'd2, 11'd0},
        '{OP_WRITE, REG_FRAME_WIDTH,  32'd4,         1'b0, 11'd0, 11'd0},
        '{OP_WRITE, REG_FRAME_HEIGHT, 32'd3,         1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h00,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h00,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h00,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'hA0,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h00,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h00,        1'b0, 11'd0, 11'd0},
        '{OP_WRITE, REG_FRAME_WIDTH,  32'd2,         1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'hFF,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h00,        1'b0, 11'd0, 11'd0},
        '{OP_PIXEL, '0,               32'h00,        1'b0, 11'd0, 11'd0}
    };

    int send_idle_tab [4] = '{0, 53, 0, 22};
    int rcv_stall_tab [4] = '{0, 0, 53, 22};

    // shadow registers and frame tracking
    logic [THR_W-1:0]   thr_cfg;
    logic [SIZE_W-1:0]  width_cfg;
    logic [SIZE_W-1:0]  height_cfg;
    logic [COORD_W-1:0] col_pos;
    logic [COORD_W-1:0] row_pos;
    logic [COORD_W-1:0] box_col_lo;
    logic [COORD_W-1:0] box_col_hi;
    logic [COORD_W-1:0] box_row_lo;
    logic [COORD_W-1:0] box_row_hi;
    logic               box_valid;

    center_t center_q [$];
    center_t want_c;
    int      mismatch_cnt  = 0;
    int      send_idle_pct = 0;
    int      rcv_stall_pct = 0;
    bit      hold_pending  = 1'b0;
    int      quiet_cycles  = 0;

    function automatic void note_failure(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
            $display("%t: %s", $realtime, msg);
    endfunction

    function automatic int active_size(input logic [SIZE_W-1:0] raw, input int lim);
        if (raw == '0)
            return 1;
        if (int'(raw) > lim)
            return lim;
        return int'(raw);
    endfunction

    function automatic void clear_tracking();
        col_pos    = '0;
        row_pos    = '0;
        box_col_lo = '0;
        box_col_hi = '0;
        box_row_lo = '0;
        box_row_hi = '0;
        box_valid  = 1'b0;
    endfunction

    function automatic void track_pixel(input logic [PIX_W-1:0] pix, output bit fires,
                                        output center_t c);
        int w;
        int h;
        bit end_col;
        bit end_row;
        w       = active_size(width_cfg, MAX_W);
        h       = active_size(height_cfg, MAX_H);
        end_col = int'(col_pos) + 1 >= w;
        end_row = int'(row_pos) + 1 >= h;
        fires   = 1'b0;
        c       = '0;
        if (pix > thr_cfg) begin
            if (!box_valid) begin
                box_col_lo = col_pos;
                box_col_hi = col_pos;
                box_row_lo = row_pos;
                box_row_hi = row_pos;
                box_valid  = 1'b1;
            end else begin
                if (col_pos < box_col_lo) box_col_lo = col_pos;
                if (col_pos > box_col_hi) box_col_hi = col_pos;
                if (row_pos < box_row_lo) box_row_lo = row_pos;
                if (row_pos > box_row_hi) box_row_hi = row_pos;
            end
        end
        if (end_col && end_row) begin
            fires = 1'b1;
            if (box_valid) begin
                c.x = box_col_lo + ((box_col_hi - box_col_lo) >> 1);
                c.y = box_row_lo + ((box_row_hi - box_row_lo) >> 1);
            end
            clear_tracking();
        end else if (end_col) begin
            col_pos = '0;
            row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endfunction

    // drop valid and wait until the block has nothing left in flight
    task automatic settle();
        s_tvalid <= 1'b0;
        while (center_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_THRESHOLD:    thr_cfg    = val[THR_W-1:0];
            REG_FRAME_WIDTH:  width_cfg  = val[SIZE_W-1:0];
            REG_FRAME_HEIGHT: height_cfg = val[SIZE_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [DATA_W-1:0] want);
        logic [DATA_W-1:0] got;
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (got !== want)
            note_failure($sformatf("register %0d read: expected %0h, got %0h", idx, want, got));
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] pix, input bit typed,
                              input center_t typed_c);
        bit      fires;
        center_t c;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        track_pixel(pix, fires, c);
        if (typed)
            center_q.push_back(typed_c);
        else if (fires)
            center_q.push_back(c);
    endtask

    task automatic load_config(input logic [THR_W-1:0] thr, input logic [SIZE_W-1:0] w,
                               input logic [SIZE_W-1:0] h);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_THRESHOLD, {junk[31:THR_W], thr});
        write_reg(REG_FRAME_WIDTH, {junk[31:SIZE_W], w});
        junk = $urandom;
        write_reg(REG_FRAME_HEIGHT, {junk[31:SIZE_W], h});
        check_reg(REG_THRESHOLD, {{(DATA_W-THR_W){1'b0}}, thr_cfg});
        check_reg(REG_FRAME_WIDTH, {{(DATA_W-SIZE_W){1'b0}}, width_cfg});
        check_reg(REG_FRAME_HEIGHT, {{(DATA_W-SIZE_W){1'b0}}, height_cfg});
    endtask

    task automatic run_frames(input int count, input int hit_pct);
        logic [PIX_W-1:0] pix;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < hit_pct)
                pix = PIX_W'($urandom_range(int'(thr_cfg), 255));
            else
                pix = PIX_W'($urandom_range(0, int'(thr_cfg)));
            push_pixel(pix, 1'b0, '0);
        end
    endtask

    initial begin : receiver
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (center_q.size() == 0) begin
                note_failure($sformatf("unexpected result x=%0d y=%0d",
                                       m_tdata[COORD_W-1:0], m_tdata[2*COORD_W-1:COORD_W]));
            end else begin
                want_c = center_q.pop_front();
                if (m_tdata[COORD_W-1:0] !== want_c.x ||
                    m_tdata[2*COORD_W-1:COORD_W] !== want_c.y ||
                    m_tdata[TDATA_W-1:2*COORD_W] !== '0)
                    note_failure($sformatf(
                        "center: expected x=%0d y=%0d, got x=%0d y=%0d pad=%0h",
                        want_c.x, want_c.y, m_tdata[COORD_W-1:0],
                        m_tdata[2*COORD_W-1:COORD_W], m_tdata[TDATA_W-1:2*COORD_W]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** threshold_blob_center: FAILED **");
            $finish;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [THR_W-1:0]  thr_raw;
        logic [SIZE_W-1:0] w_raw;
        logic [SIZE_W-1:0] h_raw;
        int                pick;
        int                frame_px;
        int                n;
        int                phase_pixels;
        center_t           typed_c;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        thr_cfg    = THRESHOLD_RST;
        width_cfg  = FRAME_WIDTH_RST;
        height_cfg = FRAME_HEIGHT_RST;
        clear_tracking();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            case (dir_tab[i].op)
                OP_READ:  check_reg(dir_tab[i].idx, dir_tab[i].value);
                OP_WRITE: write_reg(dir_tab[i].idx, dir_tab[i].value);
                default: begin
                    typed_c.x = dir_tab[i].ex;
                    typed_c.y = dir_tab[i].ey;
                    push_pixel(dir_tab[i].value[PIX_W-1:0], dir_tab[i].typed, typed_c);
                end
            endcase
        end

        // hold the result side off so the block backs up into its input
        load_config(8'h80, 12'd2, 12'd2);
        hold_pending = 1'b1;
        run_frames(40, 30);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = send_idle_tab[ph];
            rcv_stall_pct = rcv_stall_tab[ph];
            phase_pixels = 0;
            while (phase_pixels < PHASE_PIXELS) begin
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    thr_raw = '0;
                else if (pick == 1)
                    thr_raw = '1;
                else
                    thr_raw = THR_W'($urandom_range(0, 255));
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    w_raw = '0;
                else if (pick == 1)
                    w_raw = SIZE_W'($urandom_range(9, 32));
                else
                    w_raw = SIZE_W'($urandom_range(1, 8));
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    h_raw = '0;
                else if (pick == 1)
                    h_raw = SIZE_W'($urandom_range(7, 16));
                else
                    h_raw = SIZE_W'($urandom_range(1, 6));
                load_config(thr_raw, w_raw, h_raw);
                frame_px = active_size(width_cfg, MAX_W) * active_size(height_cfg, MAX_H);
                n = $urandom_range(1, 3) * frame_px;
                // leave a partial frame so the next setting lands mid-frame
                if ($urandom_range(0, 3) == 0)
                    n += $urandom_range(0, frame_px - 1);
                run_frames(n, 30);
                phase_pixels += n;
            end
        end

        // oversized width keeps the row open, a narrow width then ends it
        load_config(8'h80, '1, 12'd1);
        run_frames(60, 30);
        load_config(8'h80, 12'd5, 12'd1);
        run_frames(1, 30);

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0)
            $display("** threshold_blob_center: PASSED **");
        else
            $display("** threshold_blob_center: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
